@@ rtl/core/bog_pkg.sv @@
// Package of constants, types and helper functions for the block occupancy grid.
`default_nettype none

package bog_pkg;

  localparam int unsigned MAX_BLOCK_COLS = 16;
  localparam int unsigned MAX_BLOCK_SIZE = 256;
  localparam int unsigned MAX_IMAGE_DIM  = 2048;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned BS_W    = 9;
  localparam int unsigned INB_W   = 8;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned BX_W    = 5;
  localparam int unsigned ROW_W   = 11;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned LIM_W   = THR_W + CNT_W;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned FULL_SCALE  = 255;
  localparam int unsigned PCT_MAX     = 100;
  // floor(x / 100) equals (x * 5243) >> 19 for every x up to 255 * 100.
  localparam int unsigned RECIP_MUL   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [BS_W-1:0]  BSIZE_RST  = BS_W'(40);
  localparam logic [PCT_W-1:0] PCT_RST    = PCT_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BLOCK_SIZE   = 2'd2,
    REG_OCC_PERCENT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [BS_W-1:0]  bsize;
    logic [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } blk_res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_IMAGE_DIM)) begin
      r = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [BS_W-1:0] clamp_bsize(input logic [BS_W-1:0] v);
    logic [BS_W-1:0] r;
    if (v == '0) begin
      r = BS_W'(1);
    end else if (v > BS_W'(MAX_BLOCK_SIZE)) begin
      r = BS_W'(MAX_BLOCK_SIZE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [THR_W-1:0] calc_thr(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    logic [14:0]      scaled;
    logic [27:0]      prod;
    p = (pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct;
    scaled = 15'(p) * 15'(FULL_SCALE);
    prod = 28'(scaled) * 28'(RECIP_MUL);
    return prod[RECIP_SHIFT +: THR_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/block_occupancy_grid_top.sv @@
// Top level of the block occupancy grid: configuration registers and the two stages.
`default_nettype none

// One pixel is taken in every cycle while in_ready is high. A pixel that completes a
// block is held in the intermediate stage with its updated column accumulator, then the
// result register stores the sum compared with the threshold times the pixel count.
// in_ready falls only while both the intermediate stage and the result register hold
// a block that the consumer has not yet taken. There is no clearing pass after reset.
module block_occupancy_grid_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [bog_pkg::PIX_W-1:0]        in_pixel,
  input  wire                              in_frame_start,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [bog_pkg::ROW_W-1:0]        out_block_row,
  output logic [bog_pkg::COL_W-1:0]        out_block_col,
  output logic                             out_occupied,
  output logic                             out_last_of_frame,
  input  wire                              cfg_we,
  input  wire  [bog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bog_pkg::CFG_W-1:0]        cfg_data
);
  import bog_pkg::*;

  cfg_t     cfg_r;
  blk_res_t mid;
  logic     out_adv;
  logic     mid_free;
  logic     accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.bsize  <= BSIZE_RST;
      cfg_r.thr    <= calc_thr(PCT_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg_r.width  <= clamp_dim(cfg_data);
        REG_IMAGE_HEIGHT: cfg_r.height <= clamp_dim(cfg_data);
        REG_BLOCK_SIZE:   cfg_r.bsize  <= clamp_bsize(cfg_data[BS_W-1:0]);
        REG_OCC_PERCENT:  cfg_r.thr    <= calc_thr(cfg_data[PCT_W-1:0]);
        default: ;
      endcase
    end
  end

  assign mid_free = !mid.valid || out_adv;
  assign in_ready = mid_free;
  assign accept   = in_valid && mid_free;

  bog_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel       (in_pixel),
    .frame_start (in_frame_start),
    .cfg         (cfg_r),
    .mid_free    (mid_free),
    .mid         (mid)
  );

  bog_decide u_decide (
    .clk               (clk),
    .rst_n             (rst_n),
    .mid               (mid),
    .thr               (cfg_r.thr),
    .out_adv           (out_adv),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_row     (out_block_row),
    .out_block_col     (out_block_col),
    .out_occupied      (out_occupied),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire

@@ rtl/core/bog_accum.sv @@
// Raster position tracking and per-column block accumulators.
`default_nettype none

module bog_accum (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         accept,
  input  wire  [bog_pkg::PIX_W-1:0]   pixel,
  input  wire                         frame_start,
  input  wire  bog_pkg::cfg_t         cfg,
  input  wire                         mid_free,
  output bog_pkg::blk_res_t           mid
);
  import bog_pkg::*;

  logic [POS_W-1:0] pixel_x_r, pixel_y_r;
  logic [INB_W-1:0] x_in_block_r, y_in_block_r;
  logic [BX_W-1:0]  block_x_r;
  logic [ROW_W-1:0] block_y_r;
  logic [SUM_W-1:0] sum_r [MAX_BLOCK_COLS];
  logic [CNT_W-1:0] cnt_r [MAX_BLOCK_COLS];
  blk_res_t         mid_r, mid_nxt;

  logic [POS_W-1:0] px, py;
  logic [INB_W-1:0] xib, yib;
  logic [BX_W-1:0]  bx;
  logic [ROW_W-1:0] by;
  logic [COL_W-1:0] idx;
  logic             in_range;
  logic [SUM_W-1:0] sum_old, sum_nxt;
  logic [CNT_W-1:0] cnt_old, cnt_nxt;
  logic [SUM_W:0]   sum_add;
  logic [CNT_W:0]   cnt_add;
  logic             row_end, y_end, frame_end, bcol_end, yb_end, emit, last;

  assign px  = frame_start ? '0 : pixel_x_r;
  assign py  = frame_start ? '0 : pixel_y_r;
  assign xib = frame_start ? '0 : x_in_block_r;
  assign yib = frame_start ? '0 : y_in_block_r;
  assign bx  = frame_start ? '0 : block_x_r;
  assign by  = frame_start ? '0 : block_y_r;

  assign in_range = (bx < BX_W'(MAX_BLOCK_COLS));
  assign idx      = bx[COL_W-1:0];
  assign sum_old  = frame_start ? '0 : sum_r[idx];
  assign cnt_old  = frame_start ? '0 : cnt_r[idx];
  assign sum_add  = {1'b0, sum_old} + (SUM_W+1)'(pixel);
  assign cnt_add  = {1'b0, cnt_old} + (CNT_W+1)'(1);
  assign sum_nxt  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign cnt_nxt  = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];

  assign row_end   = ((DIM_W'(px) + DIM_W'(1)) >= cfg.width);
  assign y_end     = ((DIM_W'(py) + DIM_W'(1)) >= cfg.height);
  assign frame_end = row_end && y_end;
  assign bcol_end  = ((BS_W'(xib) + BS_W'(1)) >= cfg.bsize) || row_end;
  assign yb_end    = ((BS_W'(yib) + BS_W'(1)) >= cfg.bsize);
  assign emit      = in_range && bcol_end && (yb_end || y_end);
  assign last      = y_end && (row_end || (bx == BX_W'(MAX_BLOCK_COLS - 1)));

  always_comb begin
    mid_nxt = mid_r;
    if (mid_free) begin
      mid_nxt.valid = accept && emit;
    end
    if (accept && emit) begin
      mid_nxt.sum  = sum_nxt;
      mid_nxt.cnt  = cnt_nxt;
      mid_nxt.row  = by;
      mid_nxt.col  = idx;
      mid_nxt.last = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
    end else begin
      mid_r.valid <= mid_nxt.valid;
    end
    mid_r.sum  <= mid_nxt.sum;
    mid_r.cnt  <= mid_nxt.cnt;
    mid_r.row  <= mid_nxt.row;
    mid_r.col  <= mid_nxt.col;
    mid_r.last <= mid_nxt.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCK_COLS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < MAX_BLOCK_COLS; i++) begin
        if (in_range && (idx == COL_W'(i))) begin
          sum_r[i] <= emit ? '0 : sum_nxt;
          cnt_r[i] <= emit ? '0 : cnt_nxt;
        end else if (frame_start) begin
          sum_r[i] <= '0;
          cnt_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_x_r    <= '0;
      pixel_y_r    <= '0;
      x_in_block_r <= '0;
      y_in_block_r <= '0;
      block_x_r    <= '0;
      block_y_r    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        pixel_x_r    <= '0;
        pixel_y_r    <= '0;
        x_in_block_r <= '0;
        y_in_block_r <= '0;
        block_x_r    <= '0;
        block_y_r    <= '0;
      end else if (row_end) begin
        pixel_x_r    <= '0;
        x_in_block_r <= '0;
        block_x_r    <= '0;
        pixel_y_r    <= py + POS_W'(1);
        block_y_r    <= yb_end ? (by + ROW_W'(1)) : by;
        y_in_block_r <= yb_end ? '0 : (yib + INB_W'(1));
      end else begin
        pixel_x_r    <= px + POS_W'(1);
        pixel_y_r    <= py;
        y_in_block_r <= yib;
        block_y_r    <= by;
        x_in_block_r <= bcol_end ? '0 : (xib + INB_W'(1));
        block_x_r    <= (bcol_end && in_range) ? (bx + BX_W'(1)) : bx;
      end
    end
  end

  assign mid = mid_r;

endmodule

`default_nettype wire

@@ rtl/core/bog_decide.sv @@
// Occupancy comparison and the registered result stage.
`default_nettype none

module bog_decide (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  bog_pkg::blk_res_t      mid,
  input  wire  [bog_pkg::THR_W-1:0]    thr,
  output logic                         out_adv,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bog_pkg::ROW_W-1:0]    out_block_row,
  output logic [bog_pkg::COL_W-1:0]    out_block_col,
  output logic                         out_occupied,
  output logic                         out_last_of_frame
);
  import bog_pkg::*;

  logic             out_valid_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             occ_r, last_r;
  logic [LIM_W-1:0] lim;
  logic             occ;

  assign lim     = LIM_W'(thr) * LIM_W'(mid.cnt);
  assign occ     = (LIM_W'(mid.sum) > lim);
  assign out_adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= mid.valid;
    end
    if (out_adv && mid.valid) begin
      row_r  <= mid.row;
      col_r  <= mid.col;
      occ_r  <= occ;
      last_r <= mid.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_row     = row_r;
  assign out_block_col     = col_r;
  assign out_occupied      = occ_r;
  assign out_last_of_frame = last_r;

endmodule

`default_nettype wire

@@ rtl/core/bog_checker.sv @@
// Port-level checker for the block occupancy grid and its bind to the top level.
`default_nettype none

module bog_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  input  wire                           in_ready,
  input  wire                           out_valid,
  input  wire                           out_ready,
  input  wire  [bog_pkg::ROW_W-1:0]     out_block_row,
  input  wire  [bog_pkg::COL_W-1:0]     out_block_col,
  input  wire                           out_occupied,
  input  wire                           out_last_of_frame
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_row) &&
      $stable(out_block_col) && $stable(out_occupied) && $stable(out_last_of_frame))
    else $error("result payload changed while stalled");

  // Input back-pressure only arises from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // A new result follows an accepted input transaction.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an accepted pixel");

  // The result register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind block_occupancy_grid_top bog_checker u_bog_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_block_row     (out_block_row),
  .out_block_col     (out_block_col),
  .out_occupied      (out_occupied),
  .out_last_of_frame (out_last_of_frame)
);

`default_nettype wire

@@ tb/tb_block_occupancy_grid_top.sv @@
// Self-checking testbench of the block occupancy grid: pixel frames in, block results checked.
import bog_pkg::*;

typedef struct packed {
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             occupied;
  logic             last;
} block_result_t;

class grid_scoreboard;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [BS_W-1:0]   bsize_reg;
  logic [PCT_W-1:0]  pct_reg;
  bit [POS_W-1:0]    pos_x;
  bit [POS_W-1:0]    pos_y;
  bit [INB_W-1:0]    x_in;
  bit [INB_W-1:0]    y_in;
  bit [BX_W-1:0]     blk_x;
  bit [ROW_W-1:0]    blk_y;
  bit [SUM_W-1:0]    col_sums [MAX_BLOCK_COLS];
  bit [CNT_W-1:0]    col_counts [MAX_BLOCK_COLS];
  block_result_t     expected_blocks [$];
  int                mismatches;

  function new();
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    bsize_reg = BSIZE_RST;
    pct_reg = PCT_RST;
    mismatches = 0;
    clear_position();
  endfunction

  function int clamp_size(int v, int hi);
    if (v == 0) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  function void clear_position();
    pos_x = '0;
    pos_y = '0;
    x_in = '0;
    y_in = '0;
    blk_x = '0;
    blk_y = '0;
  endfunction

  function int threshold();
    int pct;
    pct = (pct_reg > PCT_MAX) ? PCT_MAX : int'(pct_reg);
    return (FULL_SCALE * pct) / PCT_MAX;
  endfunction

  function int frame_pixels();
    return clamp_size(width_reg, MAX_IMAGE_DIM) * clamp_size(height_reg, MAX_IMAGE_DIM);
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_IMAGE_WIDTH:  width_reg = data;
      REG_IMAGE_HEIGHT: height_reg = data;
      REG_BLOCK_SIZE:   bsize_reg = data[BS_W-1:0];
      REG_OCC_PERCENT:  pct_reg = data[PCT_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_pixel(logic [PIX_W-1:0] pix, logic fs);
    int w, h, bs, s, c;
    bit row_end, last_row, frame_end, col_done, brow_done;
    block_result_t r;
    w = clamp_size(width_reg, MAX_IMAGE_DIM);
    h = clamp_size(height_reg, MAX_IMAGE_DIM);
    bs = clamp_size(bsize_reg, MAX_BLOCK_SIZE);
    if (fs) begin
      clear_position();
      foreach (col_sums[i]) begin
        col_sums[i] = '0;
        col_counts[i] = '0;
      end
    end
    row_end = (int'(pos_x) + 1 >= w);
    last_row = (int'(pos_y) + 1 >= h);
    frame_end = row_end && last_row;
    col_done = (int'(x_in) + 1 >= bs) || row_end;
    brow_done = (int'(y_in) + 1 >= bs) || last_row;
    if (blk_x < MAX_BLOCK_COLS) begin
      s = int'(col_sums[blk_x]) + int'(pix);
      c = int'(col_counts[blk_x]) + 1;
      col_sums[blk_x] = (s > (1 << SUM_W) - 1) ? (1 << SUM_W) - 1 : s;
      col_counts[blk_x] = (c > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : c;
      if (col_done && brow_done) begin
        r.row = blk_y;
        r.col = blk_x[COL_W-1:0];
        r.occupied = (longint'(col_sums[blk_x]) >
                      longint'(threshold()) * longint'(col_counts[blk_x]));
        r.last = last_row && (row_end || blk_x == MAX_BLOCK_COLS - 1);
        expected_blocks.push_back(r);
        col_sums[blk_x] = '0;
        col_counts[blk_x] = '0;
      end
    end
    if (frame_end) begin
      clear_position();
    end else if (row_end) begin
      pos_x = '0;
      x_in = '0;
      blk_x = '0;
      pos_y = pos_y + 1'b1;
      if (int'(y_in) + 1 >= bs) begin
        y_in = '0;
        blk_y = blk_y + 1'b1;
      end else begin
        y_in = y_in + 1'b1;
      end
    end else begin
      pos_x = pos_x + 1'b1;
      if (col_done) begin
        x_in = '0;
        if (blk_x < MAX_BLOCK_COLS) begin
          blk_x = blk_x + 1'b1;
        end
      end else begin
        x_in = x_in + 1'b1;
      end
    end
  endfunction

  function void check_block(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic occ,
                            logic last);
    block_result_t e;
    if (expected_blocks.size() == 0) begin
      $error("block result with none pending: row %0d col %0d", row, col);
      mismatches++;
      return;
    end
    e = expected_blocks.pop_front();
    if (row !== e.row) begin
      $error("block_row: expected %0d, actual %0d", e.row, row);
      mismatches++;
    end
    if (col !== e.col) begin
      $error("block_col: expected %0d, actual %0d", e.col, col);
      mismatches++;
    end
    if (occ !== e.occupied) begin
      $error("occupied: expected %0d, actual %0d", e.occupied, occ);
      mismatches++;
    end
    if (last !== e.last) begin
      $error("last_of_frame: expected %0d, actual %0d", e.last, last);
      mismatches++;
    end
  endfunction
endclass

module tb_block_occupancy_grid_top;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROW_W-1:0]     out_block_row;
  logic [COL_W-1:0]     out_block_col;
  logic                 out_occupied;
  logic                 out_last_of_frame;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  grid_scoreboard sb = new();

  block_occupancy_grid_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel(in_pixel),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_block_row(out_block_row),
    .out_block_col(out_block_col),
    .out_occupied(out_occupied),
    .out_last_of_frame(out_last_of_frame),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.write_register(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.take_pixel(in_pixel, in_frame_start);
      end
      if (out_valid && out_ready) begin
        sb.check_block(out_block_row, out_block_col, out_occupied, out_last_of_frame);
      end
    end
  end

  // A toggle of hold_req starts a long stretch in which no result transaction is taken.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int value);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
  endtask

  task automatic set_config(int w, int h, int bs, int pct);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BLOCK_SIZE, bs);
    write_reg(REG_OCC_PERCENT, pct);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(int m);
    case (m % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 85; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 85; end
      default: begin idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  task automatic run_phase(int budget);
    int sent, full, len, kind, style, level, t, i;
    logic [PIX_W-1:0] pix;
    logic fs;
    sent = 0;
    while (sent < budget) begin
      full = sb.frame_pixels();
      kind = $urandom_range(9);
      style = $urandom_range(3);
      level = (style == 1) ? $urandom_range(100) : $urandom_range(255);
      if (kind == 9) begin
        len = $urandom_range(20, 1);
      end else if (kind == 8) begin
        len = $urandom_range(full, 1);
      end else begin
        len = full;
      end
      for (i = 0; i < len && sent < budget; i++) begin
        case (style)
          0: pix = PIX_W'($urandom_range(255));
          1: pix = ($urandom_range(99) < level) ? 8'd255 : 8'd0;
          2: begin
            t = sb.threshold() + int'($urandom_range(4)) - 2;
            pix = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : PIX_W'(t);
          end
          default: pix = PIX_W'(level);
        endcase
        if (kind == 9) begin
          fs = ($urandom_range(15) == 0);
        end else begin
          fs = (i == 0) && (kind != 7);
        end
        send_pixel(pix, fs);
        sent++;
      end
    end
  endtask

  initial begin
    logic [PIX_W-1:0] tiny_frame [12];
    int p, w, h, bs, pct;
    tiny_frame = '{8'd255, 8'd255, 8'd0, 8'd0,
                   8'd255, 8'd0,   8'd0, 8'd0,
                   8'd255, 8'd255, 8'd0, 8'd255};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(0);
    set_config(4, 3, 2, 50);
    foreach (tiny_frame[i]) begin
      send_pixel(tiny_frame[i], i == 0);
    end
    drain();
    set_config(1, 1, 1, 100);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd254, 1'b0);
    drain();
    set_config(1, 1, 1, 0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd0, 1'b1);
    drain();
    set_config(0, 4095, 0, 127);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    drain();
    // The frame is left part way down; the smaller height ends it at the next row end.
    set_config(3, 2, 511, 50);
    repeat (4) send_pixel(PIX_W'($urandom_range(255)), 1'b0);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd55, 1'b0);
    send_pixel(8'd255, 1'b0);
    drain();

    set_config(2048, 1, 1, 50);
    set_mode(2);
    run_phase(300);
    drain();
    set_config(1, 2048, 1, 100);
    set_mode(1);
    run_phase(100);
    drain();
    set_config(260, 1, 256, 0);
    set_mode(3);
    run_phase(260);
    drain();

    // Every pixel completes a block while the consumer holds off, so the input stalls.
    set_config(8, 4, 1, 50);
    set_mode(0);
    hold_req <= ~hold_req;
    run_phase(150);
    drain();

    for (p = 0; p < 8; p++) begin
      w = $urandom_range(40, 1);
      h = $urandom_range(12, 1);
      bs = $urandom_range(8, 1);
      pct = $urandom_range(100);
      if ($urandom_range(3) == 0) begin
        w = $urandom_range(70, 17);
        bs = $urandom_range(3, 1);
      end
      if ($urandom_range(7) == 0) w = $urandom_range(1) ? 0 : 4095;
      if ($urandom_range(7) == 0) h = $urandom_range(1) ? 0 : 4095;
      if ($urandom_range(7) == 0) bs = $urandom_range(1) ? 0 : 511;
      if ($urandom_range(7) == 0) pct = $urandom_range(127, 101);
      set_config(w, h, bs, pct);
      set_mode(p);
      run_phase(130);
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
